// ===== hdl/dlr_pkg.sv =====
// Package: item types and fixed widths for the depth line rasterizer.
package dlr_pkg;

    localparam int COORD_BITS = 16;
    localparam int DEPTH_BITS = 32;
    localparam int SHADE_BITS = 8;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } t_action;

    typedef struct packed {
        t_action                       action;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [DEPTH_BITS-1:0]  start_depth;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
        logic signed [DEPTH_BITS-1:0]  end_depth;
        logic        [SHADE_BITS-1:0]  shade;
    } t_line_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic signed [DEPTH_BITS-1:0]  pixel_depth;
        logic        [SHADE_BITS-1:0]  pixel_shade;
        logic                          last;
    } t_pixel_out;

endpackage

// ===== hdl/depth_line_rasterizer.sv =====
// Depth line rasterizer: Bresenham walk with depth interpolation.
// Step item: one pixel per cycle while the output is not stalled; the pixel sits in an output register.
// Start item: when the endpoints differ, the depth step comes from the one-bit-per-cycle
//   restoring divider (states S_DIV, then S_DONE); for a single point no divide runs.
// Input stalls while the divider runs or while an unaccepted pixel waits.
// Reset (synchronous, active low) drops the line and the pending pixel.
module depth_line_rasterizer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dlr_pkg::t_line_in    i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dlr_pkg::t_pixel_out  o_out
);
    import dlr_pkg::*;

    localparam int DELTA_W   = COORD_BITS + 1;
    localparam int ERR_W     = COORD_BITS + 3;
    localparam int E2_W      = ERR_W + 1;
    localparam int DIV_STEPS = DEPTH_BITS + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic                         r_active, n_active;
    logic                         r_out_valid, n_out_valid;
    t_pixel_out                   r_out, n_out;
    logic signed [COORD_BITS-1:0] r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic signed [COORD_BITS-1:0] r_tgt_x, n_tgt_x, r_tgt_y, n_tgt_y;
    logic        [DELTA_W-1:0]    r_dx, n_dx;
    logic signed [DELTA_W:0]      r_ndy, n_ndy;
    logic signed [ERR_W-1:0]      r_err, n_err;
    logic                         r_dir_x, n_dir_x, r_dir_y, n_dir_y;
    logic        [DEPTH_BITS-1:0] r_acc, n_acc;
    logic        [DEPTH_BITS-1:0] r_step, n_step;
    logic        [SHADE_BITS-1:0] r_shade, n_shade;
    logic        [DEPTH_BITS:0]   r_num, n_num;
    logic        [DELTA_W-1:0]    r_den, n_den;
    logic        [DELTA_W:0]      r_rem, n_rem;
    logic                         r_neg, n_neg;
    logic        [CNT_W-1:0]      r_cnt, n_cnt;

    logic                         in_acc, out_acc, fin;
    logic signed [DELTA_W-1:0]    diff_x, diff_y;
    logic        [DELTA_W-1:0]    abs_x, abs_y, span;
    logic signed [DEPTH_BITS:0]   diff_z;
    logic signed [E2_W-1:0]       e2, err_sum;
    logic        [DELTA_W:0]      rem_sh;
    logic        [DELTA_W+1:0]    trial;

    assign o_in_stall  = (r_state != S_IDLE) | (r_out_valid & i_out_stall);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign out_acc     = r_out_valid & ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign fin = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);

    always_comb begin
        diff_x = DELTA_W'(i_in.end_x) - DELTA_W'(i_in.start_x);
        diff_y = DELTA_W'(i_in.end_y) - DELTA_W'(i_in.start_y);
        abs_x  = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
        abs_y  = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);
        span   = (abs_x > abs_y) ? abs_x : abs_y;
        diff_z = (DEPTH_BITS+1)'(i_in.end_depth) - (DEPTH_BITS+1)'(i_in.start_depth);
        e2     = {r_err, 1'b0};
        rem_sh = {r_rem[DELTA_W-1:0], r_num[DEPTH_BITS]};
        trial  = {1'b0, rem_sh} - {2'b00, r_den};
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_out_valid = r_out_valid & ~out_acc;
        n_out       = r_out;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_tgt_x     = r_tgt_x;
        n_tgt_y     = r_tgt_y;
        n_dx        = r_dx;
        n_ndy       = r_ndy;
        n_err       = r_err;
        n_dir_x     = r_dir_x;
        n_dir_y     = r_dir_y;
        n_acc       = r_acc;
        n_step      = r_step;
        n_shade     = r_shade;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        err_sum     = E2_W'(r_err);

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.action == ACT_START) begin
                    n_active = 1'b1;
                    n_cur_x  = i_in.start_x;
                    n_cur_y  = i_in.start_y;
                    n_tgt_x  = i_in.end_x;
                    n_tgt_y  = i_in.end_y;
                    n_dx     = abs_x;
                    n_ndy    = -$signed({1'b0, abs_y});
                    n_dir_x  = diff_x[DELTA_W-1] | (diff_x == '0);
                    n_dir_y  = diff_y[DELTA_W-1] | (diff_y == '0);
                    n_err    = ERR_W'($signed({2'b00, abs_x}) - $signed({2'b00, abs_y}));
                    n_acc    = i_in.start_depth;
                    n_shade  = i_in.shade;
                    n_neg    = diff_z[DEPTH_BITS];
                    n_num    = diff_z[DEPTH_BITS] ? (DEPTH_BITS+1)'(-diff_z)
                                                  : (DEPTH_BITS+1)'(diff_z);
                    n_den    = span;
                    n_rem    = '0;
                    n_cnt    = '0;
                    if (span == '0) begin
                        n_step = '0;
                    end else begin
                        n_state = S_DIV;
                    end
                end else if (in_acc && r_active) begin
                    n_out_valid       = 1'b1;
                    n_out.pixel_x     = r_cur_x;
                    n_out.pixel_y     = r_cur_y;
                    n_out.pixel_depth = r_acc;
                    n_out.pixel_shade = r_shade;
                    n_out.last        = fin;
                    if (fin) begin
                        n_active = 1'b0;
                    end else begin
                        if (e2 >= E2_W'(r_ndy)) begin
                            err_sum = err_sum + E2_W'(r_ndy);
                            n_cur_x = r_dir_x ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                        end
                        if (e2 <= $signed(E2_W'(r_dx))) begin
                            err_sum = err_sum + $signed(E2_W'(r_dx));
                            n_cur_y = r_dir_y ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                        end
                        n_err = ERR_W'(err_sum);
                        n_acc = r_acc + r_step;
                    end
                end
            end
            S_DIV: begin
                if (trial[DELTA_W+1]) begin
                    n_rem = rem_sh;
                    n_num = {r_num[DEPTH_BITS-1:0], 1'b0};
                end else begin
                    n_rem = trial[DELTA_W:0];
                    n_num = {r_num[DEPTH_BITS-1:0], 1'b1};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_step  = r_neg ? -r_num[DEPTH_BITS-1:0] : r_num[DEPTH_BITS-1:0];
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_out   <= n_out;
        r_cur_x <= n_cur_x;
        r_cur_y <= n_cur_y;
        r_tgt_x <= n_tgt_x;
        r_tgt_y <= n_tgt_y;
        r_dx    <= n_dx;
        r_ndy   <= n_ndy;
        r_err   <= n_err;
        r_dir_x <= n_dir_x;
        r_dir_y <= n_dir_y;
        r_acc   <= n_acc;
        r_step  <= n_step;
        r_shade <= n_shade;
        r_num   <= n_num;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_neg   <= n_neg;
    end

`ifndef SYNTHESIS
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input not stalled while divider busy");

    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.action == ACT_STEP && r_active) |=> o_out_valid)
        else $error("step on active line gave no pixel");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.action == ACT_STEP && r_active && fin) |=> (!r_active && o_out.last))
        else $error("final pixel did not end the line");

    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0 && r_cnt < CNT_W'(DIV_STEPS)))
        else $error("divider running with zero divisor or overrun count");
`endif

endmodule
